// ----- rtl/hsv_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// hsv_pkg
// Shared widths, fixed-point constants, beat types and the sector routing
// table for the HSV to RGBA8 converter.
// ============================================================================
package hsv_pkg;

   // Fixed-point formats.
   localparam int HUE_FRAC_BITS  = 6;
   localparam int UNIT_FRAC_BITS = 16;

   // Field widths.
   localparam int HUE_W   = 20;
   localparam int UNIT_W  = 17;
   localparam int ALPHA_W = 18;
   localparam int BYTE_W  = 8;
   localparam int BYTE_MAX = (1 << BYTE_W) - 1;

   localparam int UNIT_ONE = 1 << UNIT_FRAC_BITS;

   // One sector spans 60 degrees, which is 15 * 2^SPAN_LOW_BITS hue units.
   localparam int SECTORS       = 6;
   localparam int STEP_SPAN     = 15;
   localparam int SPAN_LOW_BITS = HUE_FRAC_BITS + 2;
   localparam int SECTOR_SPAN   = STEP_SPAN << SPAN_LOW_BITS;
   localparam int HUE_FULL      = SECTORS * SECTOR_SPAN;

   // A multiple of the full turn that lifts every hue to a non-negative value.
   localparam int WRAP_OFS = (((1 << (HUE_W - 1)) + HUE_FULL - 1) / HUE_FULL) * HUE_FULL;
   localparam int WRAP_W   = $clog2((1 << (HUE_W - 1)) + WRAP_OFS);

   // The coarse hue (low bits dropped) is reduced modulo SECTORS*STEP_SPAN.
   localparam int COARSE_W    = WRAP_W - SPAN_LOW_BITS;
   localparam int COARSE_MOD  = SECTORS * STEP_SPAN;
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + COARSE_MOD - 1) / COARSE_MOD;
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int QUOT_W      = $clog2((1 << COARSE_W) / COARSE_MOD + 1);
   localparam int STEP_W      = $clog2(COARSE_MOD);
   localparam int SECTOR_W    = $clog2(SECTORS);
   localparam int FINE_W      = $clog2(STEP_SPAN);
   localparam int REM_W       = FINE_W + SPAN_LOW_BITS;

   // Level arithmetic: level = round(v*17*(ONE*W - s*k) / 2^LVL_SHIFT).
   localparam longint SPAN_UNIT = longint'(UNIT_ONE) * longint'(SECTOR_SPAN);
   localparam int FAC_W     = $clog2(SPAN_UNIT + 1);
   localparam int PROD_W    = UNIT_W + REM_W;
   localparam int V17_W     = UNIT_W + 5;
   localparam int HALF_W    = FAC_W / 2;
   localparam int PP_W      = V17_W + ((FAC_W - HALF_W > HALF_W) ? FAC_W - HALF_W : HALF_W);
   localparam int LVL_SHIFT = 2 * UNIT_FRAC_BITS + HUE_FRAC_BITS + 2;
   localparam int SUM_W     = LVL_SHIFT + BYTE_W;
   localparam int VPROD_W   = UNIT_W + BYTE_W;
   localparam int APROD_W   = UNIT_FRAC_BITS + BYTE_W;

   // Which of the four levels feeds a color channel.
   typedef enum logic [1:0] {
      LVL_P,
      LVL_Q,
      LVL_T,
      LVL_V
   } level_sel_type;

   typedef struct packed {
      level_sel_type red;
      level_sel_type green;
      level_sel_type blue;
   } route_type;

   // Beat passed from the hue stage to the level stage.
   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [REM_W-1:0]    rem;
      logic [UNIT_W-1:0]   sat;
      logic [UNIT_W-1:0]   bri;
      logic [BYTE_W-1:0]   alpha;
   } sect_beat_type;

   // Sector from the reduced coarse hue, by comparison against sector edges.
   function automatic logic [SECTOR_W-1:0] sector_of(input logic [STEP_W-1:0] step);
      logic [SECTOR_W-1:0] n;
      n = '0;
      for (int i = 1; i < SECTORS; i++) begin
         if (int'(step) >= i * STEP_SPAN) begin
            n = n + 1'b1;
         end
      end
      return n;
   endfunction

   // Per-sector routing of the levels to red, green and blue.
   function automatic route_type route_of(input logic [SECTOR_W-1:0] sector);
      route_type r;
      case (sector)
         3'd0:    r = '{red: LVL_V, green: LVL_T, blue: LVL_P};
         3'd1:    r = '{red: LVL_Q, green: LVL_V, blue: LVL_P};
         3'd2:    r = '{red: LVL_P, green: LVL_V, blue: LVL_T};
         3'd3:    r = '{red: LVL_P, green: LVL_Q, blue: LVL_V};
         3'd4:    r = '{red: LVL_T, green: LVL_P, blue: LVL_V};
         default: r = '{red: LVL_V, green: LVL_P, blue: LVL_Q};
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/hsv_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// hsv_if
// Valid/ready channel interfaces for HSV pixel beats and RGBA byte beats.
// ============================================================================
interface hsv_req_if import hsv_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [HUE_W-1:0]   hue;
   logic        [UNIT_W-1:0]  saturation;
   logic        [UNIT_W-1:0]  brightness;
   logic signed [ALPHA_W-1:0] opacity;

   modport source (output valid, hue, saturation, brightness, opacity, input ready);
   modport sink   (input valid, hue, saturation, brightness, opacity, output ready);
endinterface

interface hsv_rsp_if import hsv_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] red;
   logic [BYTE_W-1:0] green;
   logic [BYTE_W-1:0] blue;
   logic [BYTE_W-1:0] opacity_byte;

   modport source (output valid, red, green, blue, opacity_byte, input ready);
   modport sink   (input valid, red, green, blue, opacity_byte, output ready);
endinterface

// ----- rtl/hsv_sector.sv -----
`timescale 1ns / 1ps
// ============================================================================
// hsv_sector
// Two pipeline stages: hue wrap and sector split, input clamping, alpha byte.
// ============================================================================
module hsv_sector import hsv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   hsv_req_if.sink       req_chan,
   output logic          out_valid,
   input  logic          out_ready,
   output sect_beat_type out_beat
);

   // Stage A: offset hue, reciprocal quotient, clamps, alpha.
   logic                va_ff;
   logic [COARSE_W-1:0] coarse_a_ff;
   logic [SPAN_LOW_BITS-1:0] low_a_ff;
   logic [QUOT_W-1:0]   quot_a_ff;
   logic [UNIT_W-1:0]   sat_a_ff;
   logic [UNIT_W-1:0]   bri_a_ff;
   logic [BYTE_W-1:0]   alpha_a_ff;

   // Stage B: sector and remainder.
   logic                vb_ff;
   logic [SECTOR_W-1:0] sector_b_ff;
   logic [REM_W-1:0]    rem_b_ff;
   logic [UNIT_W-1:0]   sat_b_ff;
   logic [UNIT_W-1:0]   bri_b_ff;
   logic [BYTE_W-1:0]   alpha_b_ff;

   logic ready_a;
   logic ready_b;

   logic [WRAP_W-1:0]           wrap_in;
   logic [COARSE_W+RECIP_W-1:0] recip_prod;
   logic [QUOT_W-1:0]           quot_in;
   logic [UNIT_W-1:0]           sat_in;
   logic [UNIT_W-1:0]           bri_in;
   logic [APROD_W-1:0]          alpha_prod;
   logic [BYTE_W-1:0]           alpha_in;
   logic                        op_ge_one;
   logic                        op_le_zero;
   logic [STEP_W-1:0]           step_in;
   logic [SECTOR_W-1:0]         sector_in;
   logic [FINE_W-1:0]           fine_in;

   assign ready_b        = !vb_ff || out_ready;
   assign ready_a        = !va_ff || ready_b;
   assign req_chan.ready = ready_a;

   always_comb begin
      wrap_in    = WRAP_W'(int'(req_chan.hue) + WRAP_OFS);
      recip_prod = wrap_in[WRAP_W-1:SPAN_LOW_BITS] * RECIP_W'(RECIP);
      quot_in    = recip_prod[RECIP_SHIFT +: QUOT_W];

      sat_in = (req_chan.saturation > UNIT_W'(UNIT_ONE)) ? UNIT_W'(UNIT_ONE)
                                                         : req_chan.saturation;
      bri_in = (req_chan.brightness > UNIT_W'(UNIT_ONE)) ? UNIT_W'(UNIT_ONE)
                                                         : req_chan.brightness;

      op_ge_one  = !req_chan.opacity[ALPHA_W-1] &&
                   (req_chan.opacity[ALPHA_W-2:UNIT_FRAC_BITS] != '0);
      op_le_zero = req_chan.opacity[ALPHA_W-1] || (req_chan.opacity == '0);
      alpha_prod = APROD_W'(req_chan.opacity[UNIT_FRAC_BITS-1:0]) * APROD_W'(BYTE_MAX)
                 + APROD_W'(UNIT_ONE / 2);
      if (op_ge_one) begin
         alpha_in = BYTE_W'(BYTE_MAX);
      end else if (op_le_zero) begin
         alpha_in = '0;
      end else begin
         alpha_in = alpha_prod[UNIT_FRAC_BITS +: BYTE_W];
      end
   end

   always_comb begin
      step_in   = STEP_W'(coarse_a_ff - COARSE_W'(quot_a_ff * COARSE_MOD));
      sector_in = sector_of(step_in);
      fine_in   = FINE_W'(step_in - STEP_W'(sector_in * STEP_SPAN));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (ready_a) begin
            va_ff <= req_chan.valid;
         end
         if (ready_b) begin
            vb_ff <= va_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         coarse_a_ff <= wrap_in[WRAP_W-1:SPAN_LOW_BITS];
         low_a_ff    <= wrap_in[SPAN_LOW_BITS-1:0];
         quot_a_ff   <= quot_in;
         sat_a_ff    <= sat_in;
         bri_a_ff    <= bri_in;
         alpha_a_ff  <= alpha_in;
      end
      if (ready_b) begin
         sector_b_ff <= sector_in;
         rem_b_ff    <= {fine_in, low_a_ff};
         sat_b_ff    <= sat_a_ff;
         bri_b_ff    <= bri_a_ff;
         alpha_b_ff  <= alpha_a_ff;
      end
   end

   assign out_valid       = vb_ff;
   assign out_beat.sector = sector_b_ff;
   assign out_beat.rem    = rem_b_ff;
   assign out_beat.sat    = sat_b_ff;
   assign out_beat.bri    = bri_b_ff;
   assign out_beat.alpha  = alpha_b_ff;

   // The exact wrap must always land in one of the six sectors.
   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      vb_ff |-> (sector_b_ff <= SECTOR_W'(SECTORS - 1)))
      else $error("hsv_sector: sector out of range");

   // The remainder must stay below one sector span.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      vb_ff |-> (rem_b_ff < REM_W'(SECTOR_SPAN)))
      else $error("hsv_sector: remainder beyond sector span");

   // A blocked beat in the last stage must not vanish.
   a_hold_b: assert property (@(posedge clock) disable iff (reset)
      (vb_ff && !out_ready) |=> vb_ff)
      else $error("hsv_sector: stalled beat dropped");

endmodule

// ----- rtl/hsv_shade.sv -----
`timescale 1ns / 1ps
// ============================================================================
// hsv_shade
// Three pipeline stages: level factors, split products, rounding and routing.
// ============================================================================
module hsv_shade import hsv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  sect_beat_type in_beat,
   hsv_rsp_if.source     rsp_chan
);

   localparam int NLVL = 3;
   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (LVL_SHIFT - 1);

   // Stage C: factors ONE*W - s*k for p, q and t; v*17; the v level itself.
   logic                vc_ff;
   logic [FAC_W-1:0]    fac_c_ff [NLVL];
   logic [V17_W-1:0]    v17_c_ff;
   logic [BYTE_W-1:0]   vlvl_c_ff;
   logic [SECTOR_W-1:0] sector_c_ff;
   logic [BYTE_W-1:0]   alpha_c_ff;

   // Stage D: high and low partial products.
   logic                vd_ff;
   logic [PP_W-1:0]     pp_hi_d_ff [NLVL];
   logic [PP_W-1:0]     pp_lo_d_ff [NLVL];
   logic [BYTE_W-1:0]   vlvl_d_ff;
   logic [SECTOR_W-1:0] sector_d_ff;
   logic [BYTE_W-1:0]   alpha_d_ff;

   // Stage E: output register.
   logic                ve_ff;
   logic [BYTE_W-1:0]   red_ff;
   logic [BYTE_W-1:0]   green_ff;
   logic [BYTE_W-1:0]   blue_ff;
   logic [BYTE_W-1:0]   alpha_e_ff;

   logic ready_c;
   logic ready_d;
   logic ready_e;

   logic [REM_W-1:0]   k_in   [NLVL];
   logic [PROD_W-1:0]  sk_in  [NLVL];
   logic [FAC_W-1:0]   fac_in [NLVL];
   logic [VPROD_W-1:0] vprod_in;
   logic [PP_W-1:0]    pp_hi_in [NLVL];
   logic [PP_W-1:0]    pp_lo_in [NLVL];
   logic [SUM_W-1:0]   sum_in [NLVL];
   logic [BYTE_W-1:0]  lvl_in [4];
   route_type          route_in;

   assign ready_e  = !ve_ff || rsp_chan.ready;
   assign ready_d  = !vd_ff || ready_e;
   assign ready_c  = !vc_ff || ready_d;
   assign in_ready = ready_c;

   always_comb begin
      k_in[LVL_P] = REM_W'(SECTOR_SPAN);
      k_in[LVL_Q] = in_beat.rem;
      k_in[LVL_T] = REM_W'(SECTOR_SPAN) - in_beat.rem;
      for (int j = 0; j < NLVL; j++) begin
         sk_in[j]  = in_beat.sat * k_in[j];
         fac_in[j] = FAC_W'(SPAN_UNIT) - FAC_W'(sk_in[j]);
      end
      vprod_in = in_beat.bri * VPROD_W'(BYTE_MAX) + VPROD_W'(UNIT_ONE / 2);
   end

   always_comb begin
      for (int j = 0; j < NLVL; j++) begin
         pp_hi_in[j] = v17_c_ff * fac_c_ff[j][FAC_W-1:HALF_W];
         pp_lo_in[j] = v17_c_ff * fac_c_ff[j][HALF_W-1:0];
      end
   end

   always_comb begin
      for (int j = 0; j < NLVL; j++) begin
         sum_in[j] = (SUM_W'(pp_hi_d_ff[j]) << HALF_W) + SUM_W'(pp_lo_d_ff[j]) + ROUND_HALF;
         lvl_in[j] = sum_in[j][LVL_SHIFT +: BYTE_W];
      end
      lvl_in[LVL_V] = vlvl_d_ff;
      route_in      = route_of(sector_d_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else begin
         if (ready_c) begin
            vc_ff <= in_valid;
         end
         if (ready_d) begin
            vd_ff <= vc_ff;
         end
         if (ready_e) begin
            ve_ff <= vd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_c) begin
         for (int j = 0; j < NLVL; j++) begin
            fac_c_ff[j] <= fac_in[j];
         end
         v17_c_ff    <= V17_W'(in_beat.bri * 17);
         vlvl_c_ff   <= vprod_in[UNIT_FRAC_BITS +: BYTE_W];
         sector_c_ff <= in_beat.sector;
         alpha_c_ff  <= in_beat.alpha;
      end
      if (ready_d) begin
         for (int j = 0; j < NLVL; j++) begin
            pp_hi_d_ff[j] <= pp_hi_in[j];
            pp_lo_d_ff[j] <= pp_lo_in[j];
         end
         vlvl_d_ff   <= vlvl_c_ff;
         sector_d_ff <= sector_c_ff;
         alpha_d_ff  <= alpha_c_ff;
      end
      if (ready_e) begin
         red_ff     <= lvl_in[route_in.red];
         green_ff   <= lvl_in[route_in.green];
         blue_ff    <= lvl_in[route_in.blue];
         alpha_e_ff <= alpha_d_ff;
      end
   end

   assign rsp_chan.valid        = ve_ff;
   assign rsp_chan.red          = red_ff;
   assign rsp_chan.green        = green_ff;
   assign rsp_chan.blue         = blue_ff;
   assign rsp_chan.opacity_byte = alpha_e_ff;

   // p uses the full sector span, so its factor is never above q or t.
   a_fac_order: assert property (@(posedge clock) disable iff (reset)
      vc_ff |-> ((fac_c_ff[LVL_P] <= fac_c_ff[LVL_Q]) &&
                 (fac_c_ff[LVL_P] <= fac_c_ff[LVL_T])))
      else $error("hsv_shade: level factor order broken");

   // A beat held by back-pressure in the product stage must stay.
   a_hold_d: assert property (@(posedge clock) disable iff (reset)
      (vd_ff && !ready_e) |=> vd_ff)
      else $error("hsv_shade: stalled beat dropped");

endmodule

// ----- rtl/hsv_to_rgb8.sv -----
`timescale 1ns / 1ps
// ============================================================================
// hsv_to_rgb8
// HSV pixel with alpha to 8-bit RGBA, fully pipelined, one pixel per clock if unstalled.
// ============================================================================
// Usage:
//   req_chan carries one HSV pixel per beat: hue (signed, 1/64 degree units,
//   any value, wrapped modulo 360 degrees), saturation and brightness
//   (unsigned Q1.16, values above 1.0 are clamped) and opacity (signed Q1.16).
//   rsp_chan returns one beat per pixel with red, green, blue and
//   opacity_byte, in input order.
//   An accepted beat passes through five register stages in order (hue wrap,
//   sector split, level factors, partial products, rounding with channel
//   routing), each holding one pixel, before it appears on rsp_chan.
//   Throughput is one pixel per clock while rsp_chan does not stall.
//   Each stage advances when its successor is empty or advancing, so a stall
//   on rsp_chan first closes up any bubbles and only lowers req_chan.ready
//   once all five stages hold a pixel. Nothing is dropped or repeated.
//   Synchronous reset empties the pipeline; no payload is cleared and there
//   is no other state, so the block is ready in the first cycle after reset.
// ============================================================================
module hsv_to_rgb8 import hsv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hsv_req_if.sink    req_chan,
   hsv_rsp_if.source  rsp_chan
);

   // Beat between the hue section and the level section.
   logic          mid_valid;
   logic          mid_ready;
   sect_beat_type mid_beat;

   // Hue wrap to sector and remainder, plus the input clamps and the alpha
   // byte, which needs no more work after this point.
   hsv_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_beat  (mid_beat)
   );

   // The p, q, t and v levels with exact rounding, then the per-sector
   // selection onto red, green and blue, into the output register.
   hsv_shade u_shade (
      .clock    (clock),
      .reset    (reset),
      .in_valid (mid_valid),
      .in_ready (mid_ready),
      .in_beat  (mid_beat),
      .rsp_chan (rsp_chan)
   );

endmodule
